// ===== rtl/tcp_handshake_flow_tracker_macros.svh =====
// Assertion macros for the TCP handshake flow tracker.
// Used by the checker module; depends on nothing else.
`ifndef TCP_HANDSHAKE_FLOW_TRACKER_MACROS_SVH
`define TCP_HANDSHAKE_FLOW_TRACKER_MACROS_SVH

// Implication checked in the same cycle.
`define THFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tracker assertion failed");

// Implication checked in the following cycle.
`define THFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tracker assertion failed");

`endif

// ===== rtl/thft_pkg.sv =====
// Package of the TCP handshake flow tracker: word types, status codes and constants.
// Used by every module of the block but thft_fifo; depends on nothing.
`default_nettype none
package thft_pkg;

	localparam int TABLE_SETS_DEF = 256;
	localparam int TABLE_WAYS_DEF = 4;
	localparam int SET_IDX_W      = 17;
	localparam int KEY_W          = 64;
	localparam int CNT_W          = 32;
	localparam int NUM_CNT        = 5;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_SYN       = 3'd1;
	localparam logic [2:0] ST_SYNACK    = 3'd2;
	localparam logic [2:0] ST_HS        = 3'd3;
	localparam logic [2:0] ST_DATA      = 3'd4;
	localparam logic [2:0] ST_UNTRACKED = 3'd5;

	localparam int CNT_SEEN   = 0;
	localparam int CNT_SYN    = 1;
	localparam int CNT_SYNACK = 2;
	localparam int CNT_HS     = 3;
	localparam int CNT_DATA   = 4;

	typedef struct packed {
		logic [KEY_W-1:0] flow_key;
		logic             syn_flag;
		logic             ack_flag;
		logic [3:0]       header_words;
		logic [15:0]      bytes_from_transport;
	} packet_t;

	typedef struct packed {
		logic [2:0]       flow_status;
		logic             new_flow;
		logic             table_full;
		logic [CNT_W-1:0] flows_seen;
		logic [CNT_W-1:0] flows_with_syn;
		logic [CNT_W-1:0] flows_with_synack;
		logic [CNT_W-1:0] flows_handshaken;
		logic [CNT_W-1:0] flows_with_data;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0]     flow_key;
		logic                 syn_flag;
		logic                 ack_flag;
		logic                 payload;
		logic [SET_IDX_W-1:0] set_idx;
	} work_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/thft_fifo.sv =====
// Two-entry word queue used between the stages of the flow tracker.
// Depends on nothing but the word type handed in as a parameter.
`default_nettype none
module thft_fifo #(
	parameter type T = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     wdata,
	output logic      full,
	input  wire logic pop,
	output T          rdata,
	output logic      empty
);

	T           mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule
`default_nettype wire

// ===== rtl/thft_front.sv =====
// Front stage of the flow tracker: accepts packets, finds the payload and the set index.
// Depends on thft_pkg.
`default_nettype none
module thft_front #(
	parameter int TABLE_SETS = thft_pkg::TABLE_SETS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire thft_pkg::packet_t packet,
	output logic                  full,
	output logic                  work_push,
	output thft_pkg::work_t       work,
	input  wire logic             work_full
);

	localparam int          SET_W  = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
	localparam bit          POW2   = ((TABLE_SETS & (TABLE_SETS - 1)) == 0);
	localparam logic [47:0] RCP    =
		48'(((64'd1 << 48) + 64'(TABLE_SETS) - 64'd1) / 64'(TABLE_SETS));
	localparam logic [31:0] SETS_C = 32'(TABLE_SETS);

	thft_pkg::packet_t item_q;
	logic              busy_q;
	logic [2:0]        cnt_q;
	logic              ph_q;
	logic [15:0]       rem_q;
	logic [31:0]       num_q;
	logic [15:0]       quo_q;
	logic [15:0]       chunk;
	logic [31:0]       num;
	logic [79:0]       prod;
	logic [31:0]       rem_full;
	logic              accept;
	thft_pkg::packet_t src;
	logic [SET_W-1:0]  set_idx;

	assign full   = POW2 ? work_full : busy_q;
	assign accept = push && !full;
	assign src    = POW2 ? packet : item_q;

	// The key is reduced sixteen bits at a time, most significant first: the quotient
	// of each partial value comes from a reciprocal product, the remainder follows.
	assign chunk    = item_q.flow_key[{~cnt_q[1:0], 4'b0000} +: 16];
	assign num      = {rem_q, chunk};
	assign prod     = {48'd0, num} * {32'd0, RCP};
	assign rem_full = num_q - ({16'd0, quo_q} * SETS_C);

	assign set_idx = POW2 ? (src.flow_key[SET_W-1:0] & SET_W'(TABLE_SETS - 1))
		: rem_q[SET_W-1:0];

	assign work_push = POW2 ? accept : (busy_q && cnt_q[2] && !work_full);

	always_comb begin
		work          = '0;
		work.flow_key = src.flow_key;
		work.syn_flag = src.syn_flag;
		work.ack_flag = src.ack_flag;
		work.payload  = {2'b00, src.bytes_from_transport} > {12'd0, src.header_words, 2'b00};
		work.set_idx  = thft_pkg::SET_IDX_W'(set_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ph_q   <= 1'b0;
			rem_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
		end else if (!POW2) begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				ph_q   <= 1'b0;
				rem_q  <= '0;
			end else if (busy_q && !cnt_q[2]) begin
				if (!ph_q) begin
					num_q <= num;
					quo_q <= prod[63:48];
					ph_q  <= 1'b1;
				end else begin
					rem_q <= rem_full[15:0];
					cnt_q <= cnt_q + 3'd1;
					ph_q  <= 1'b0;
				end
			end else if (work_push) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= packet;
	end

endmodule
`default_nettype wire

// ===== rtl/thft_back.sv =====
// Back stage of the flow tracker: flow table, handshake state update and counters.
// Depends on thft_pkg.
`default_nettype none
module thft_back #(
	parameter int TABLE_SETS = thft_pkg::TABLE_SETS_DEF,
	parameter int TABLE_WAYS = thft_pkg::TABLE_WAYS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire thft_pkg::work_t work,
	input  wire logic            work_empty,
	output logic                 work_pop,
	output logic                 res_push,
	output thft_pkg::result_t    res,
	input  wire logic            res_full
);

	localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
	localparam int WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
	localparam int KW    = thft_pkg::KEY_W;
	localparam int CW    = thft_pkg::CNT_W;

	logic [TABLE_WAYS-1:0]         vld_mem [TABLE_SETS];
	logic [TABLE_WAYS-1:0][KW-1:0] key_mem [TABLE_SETS];
	logic [TABLE_WAYS-1:0][2:0]    st_mem  [TABLE_SETS];

	thft_pkg::back_state_t state_q, state_d;
	logic [SET_W:0]                clr_q;
	thft_pkg::work_t               work_q;
	logic [TABLE_WAYS-1:0]         rd_vld_q;
	logic [TABLE_WAYS-1:0][KW-1:0] rd_key_q;
	logic [TABLE_WAYS-1:0][2:0]    rd_st_q;
	logic [CW-1:0]                 cnt_q [thft_pkg::NUM_CNT];
	logic [CW-1:0]                 cnt_d [thft_pkg::NUM_CNT];
	logic [thft_pkg::NUM_CNT-1:0]  bump;

	logic                          start;
	logic                          clr_we;
	logic                          upd_we;
	logic                          hit_any;
	logic                          free_any;
	logic [WAY_W-1:0]              hit_way;
	logic [WAY_W-1:0]              free_way;
	logic [WAY_W-1:0]              way;
	logic                          tracked;
	logic [2:0]                    st_old;
	logic [2:0]                    st_new;
	logic [SET_W-1:0]              upd_set;
	logic [TABLE_WAYS-1:0]         wr_vld;
	logic [TABLE_WAYS-1:0][KW-1:0] wr_key;
	logic [TABLE_WAYS-1:0][2:0]    wr_st;

	assign start   = (state_q == thft_pkg::BK_IDLE) && !work_empty && !res_full;
	assign upd_set = work_q.set_idx[SET_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			thft_pkg::BK_CLEAR:  if (clr_q == (SET_W+1)'(TABLE_SETS - 1)) state_d = thft_pkg::BK_IDLE;
			thft_pkg::BK_IDLE:   if (start) state_d = thft_pkg::BK_UPDATE;
			thft_pkg::BK_UPDATE: state_d = thft_pkg::BK_IDLE;
			default:             state_d = thft_pkg::BK_CLEAR;
		endcase
	end

	always_comb begin
		work_pop = start;
		clr_we   = (state_q == thft_pkg::BK_CLEAR);
		res_push = (state_q == thft_pkg::BK_UPDATE);
		upd_we   = (state_q == thft_pkg::BK_UPDATE) && tracked;
	end

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < TABLE_WAYS; w++) begin
			if (rd_vld_q[w]) begin
				if (!hit_any && rd_key_q[w] == work_q.flow_key) begin
					hit_any = 1'b1;
					hit_way = WAY_W'(w);
				end
			end else if (!free_any) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	assign tracked = hit_any || free_any;
	assign way     = hit_any ? hit_way : free_way;
	assign st_old  = hit_any ? rd_st_q[hit_way] : thft_pkg::ST_FOUND;

	always_comb begin
		st_new = st_old;
		bump   = '0;
		bump[thft_pkg::CNT_SEEN] = !hit_any && free_any;
		if (work_q.syn_flag && !work_q.ack_flag) begin
			bump[thft_pkg::CNT_SYN] = (st_old == thft_pkg::ST_FOUND);
			st_new = thft_pkg::ST_SYN;
		end else if (work_q.syn_flag && work_q.ack_flag) begin
			if (st_old == thft_pkg::ST_SYN) begin
				st_new = thft_pkg::ST_SYNACK;
				bump[thft_pkg::CNT_SYNACK] = 1'b1;
			end
		end else if (work_q.ack_flag) begin
			if (st_old == thft_pkg::ST_SYNACK) begin
				st_new = work_q.payload ? thft_pkg::ST_DATA : thft_pkg::ST_HS;
				bump[thft_pkg::CNT_HS]   = 1'b1;
				bump[thft_pkg::CNT_DATA] = work_q.payload;
			end else if (st_old == thft_pkg::ST_HS && work_q.payload) begin
				st_new = thft_pkg::ST_DATA;
				bump[thft_pkg::CNT_DATA] = 1'b1;
			end
		end else if (work_q.payload && st_old == thft_pkg::ST_HS) begin
			st_new = thft_pkg::ST_DATA;
			bump[thft_pkg::CNT_DATA] = 1'b1;
		end
		if (!tracked) bump = '0;
	end

	always_comb begin
		for (int c = 0; c < thft_pkg::NUM_CNT; c++) begin
			cnt_d[c] = (bump[c] && cnt_q[c] != '1) ? cnt_q[c] + CW'(1) : cnt_q[c];
		end
	end

	always_comb begin
		wr_vld      = rd_vld_q;
		wr_key      = rd_key_q;
		wr_st       = rd_st_q;
		wr_vld[way] = 1'b1;
		wr_key[way] = work_q.flow_key;
		wr_st[way]  = st_new;
	end

	always_comb begin
		res                   = '0;
		res.flow_status       = tracked ? st_new : thft_pkg::ST_UNTRACKED;
		res.new_flow          = !hit_any && free_any;
		res.table_full        = !tracked;
		res.flows_seen        = cnt_d[thft_pkg::CNT_SEEN];
		res.flows_with_syn    = cnt_d[thft_pkg::CNT_SYN];
		res.flows_with_synack = cnt_d[thft_pkg::CNT_SYNACK];
		res.flows_handshaken  = cnt_d[thft_pkg::CNT_HS];
		res.flows_with_data   = cnt_d[thft_pkg::CNT_DATA];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thft_pkg::BK_CLEAR;
			clr_q   <= '0;
			for (int c = 0; c < thft_pkg::NUM_CNT; c++) cnt_q[c] <= '0;
		end else begin
			state_q <= state_d;
			if (clr_we) clr_q <= clr_q + (SET_W+1)'(1);
			if (res_push) begin
				for (int c = 0; c < thft_pkg::NUM_CNT; c++) cnt_q[c] <= cnt_d[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) work_q <= work;
	end

	always_ff @(posedge clk) begin
		if (clr_we) begin
			vld_mem[clr_q[SET_W-1:0]] <= '0;
		end else if (upd_we) begin
			vld_mem[upd_set] <= wr_vld;
			key_mem[upd_set] <= wr_key;
			st_mem[upd_set]  <= wr_st;
		end
		if (start) begin
			rd_vld_q <= vld_mem[work.set_idx[SET_W-1:0]];
			rd_key_q <= key_mem[work.set_idx[SET_W-1:0]];
			rd_st_q  <= st_mem[work.set_idx[SET_W-1:0]];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tcp_handshake_flow_tracker.sv =====
// Top level of the TCP handshake flow tracker: front stage, work queue, back stage, result queue.
// Depends on thft_pkg, thft_fifo, thft_front and thft_back.
//
// Channel   Handshake       Word
// packet    push / full     thft_pkg::packet_t, one parsed TCP packet
// result    pop / empty     thft_pkg::result_t, flow status and counters
//
// The back stage handles one packet at a time: it reads the set on taking a packet, then
// updates and writes it. With a power-of-two set count the front stage is combinational;
// otherwise it reduces the key sixteen bits at a time, taking no new packet meanwhile.
// After reset the back stage clears the valid bits of every set before the first lookup.
// Packets queue in the work queue during that pass and whenever results are not popped.
`default_nettype none
module tcp_handshake_flow_tracker #(
	parameter int TABLE_SETS = thft_pkg::TABLE_SETS_DEF,
	parameter int TABLE_WAYS = thft_pkg::TABLE_WAYS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire thft_pkg::packet_t packet,
	output logic                   full,
	input  wire logic              pop,
	output thft_pkg::result_t      result,
	output logic                   empty
);

	logic              fw_push;
	thft_pkg::work_t   fw_work;
	logic              fw_full;
	thft_pkg::work_t   bk_work;
	logic              bk_empty;
	logic              bk_pop;
	logic              res_push;
	thft_pkg::result_t res_word;
	logic              res_full;

	thft_front #(.TABLE_SETS(TABLE_SETS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.packet    (packet),
		.full      (full),
		.work_push (fw_push),
		.work      (fw_work),
		.work_full (fw_full)
	);

	thft_fifo #(.T(thft_pkg::work_t)) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fw_push),
		.wdata  (fw_work),
		.full   (fw_full),
		.pop    (bk_pop),
		.rdata  (bk_work),
		.empty  (bk_empty)
	);

	thft_back #(.TABLE_SETS(TABLE_SETS), .TABLE_WAYS(TABLE_WAYS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (bk_work),
		.work_empty (bk_empty),
		.work_pop   (bk_pop),
		.res_push   (res_push),
		.res        (res_word),
		.res_full   (res_full)
	);

	thft_fifo #(.T(thft_pkg::result_t)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_word),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire

// ===== rtl/thft_checker.sv =====
// Port checker of the TCP handshake flow tracker, bound to the top level.
// Depends on thft_pkg and tcp_handshake_flow_tracker_macros.svh.
`default_nettype none
`include "tcp_handshake_flow_tracker_macros.svh"
module thft_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              pop,
	input wire logic              empty,
	input wire thft_pkg::result_t result
);

	`THFT_ASSERT_IMP(a_full_untracked, clk, arst_n, !empty && result.table_full, result.flow_status == thft_pkg::ST_UNTRACKED && !result.new_flow)
	`THFT_ASSERT_IMP(a_syn_le_seen, clk, arst_n, !empty, result.flows_with_syn <= result.flows_seen)
	`THFT_ASSERT_IMP(a_data_le_hs, clk, arst_n, !empty, result.flows_with_data <= result.flows_handshaken)
	`THFT_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

endmodule

bind tcp_handshake_flow_tracker thft_checker u_thft_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
`default_nettype wire
